/* src/b64enc_pkg.sv */
// Shared types and the character lookup for the base64 stream encoder.
// No dependencies.
package b64enc_pkg;

    localparam int SYM_W      = 7;   // bit 6 marks a pad, bits 5:0 hold a sextet
    localparam int CHARS_MAX  = 4;
    localparam int IDX_W      = 2;

    localparam logic [SYM_W-1:0] SYM_PAD    = 7'h40;
    localparam logic [7:0]       ASCII_PAD  = 8'h3d;   // '='

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_output;
    } out_item_t;

    // One accepted byte turns into a job of one to four characters.
    typedef struct packed {
        logic [CHARS_MAX-1:0][SYM_W-1:0] sym;
        logic [IDX_W-1:0]                last_idx;
        logic                            eom;
    } job_t;

    function automatic logic [7:0] sym_to_ascii(input logic [SYM_W-1:0] sym);
        logic [5:0] s;
        logic [7:0] c;
        begin
            s = sym[5:0];
            if (sym[6])
            begin
                c = ASCII_PAD;
            end
            else if (s < 6'd26)
            begin
                c = 8'h41 + {2'b00, s};
            end
            else if (s < 6'd52)
            begin
                c = 8'h61 + {2'b00, s - 6'd26};
            end
            else if (s < 6'd62)
            begin
                c = 8'h30 + {2'b00, s - 6'd52};
            end
            else if (s == 6'd62)
            begin
                c = 8'h2b;   // '+'
            end
            else
            begin
                c = 8'h2f;   // '/'
            end
            return c;
        end
    endfunction

endpackage

/* src/b64enc_front.sv */
// Front end: accepts bytes, tracks group position and leftover bits, and
// builds the character job for each byte. Depends on b64enc_pkg.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  in_item,
    input  logic      q_full,
    output logic      q_wr,
    output job_t      q_job
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic [7:0] b;
    logic [1:0] ph;
    logic [3:0] lf;

    assign q_wr = push && !q_full;
    assign b    = in_item.data_byte;

    always_comb
    begin
        q_job          = '0;
        q_job.eom      = in_item.last_byte;
        ph             = 2'd0;
        lf             = 4'd0;
        unique case (phase_reg)
            2'd1:
            begin
                q_job.sym[0]   = {1'b0, left_reg[1:0], b[7:4]};
                q_job.last_idx = 2'd0;
                lf             = b[3:0];
                ph             = 2'd2;
            end
            2'd2:
            begin
                q_job.sym[0]   = {1'b0, left_reg, b[7:6]};
                q_job.sym[1]   = {1'b0, b[5:0]};
                q_job.last_idx = 2'd1;
                lf             = 4'd0;
                ph             = 2'd0;
            end
            default:
            begin
                q_job.sym[0]   = {1'b0, b[7:2]};
                q_job.last_idx = 2'd0;
                lf             = {2'b00, b[1:0]};
                ph             = 2'd1;
            end
        endcase

        phase_next = ph;
        left_next  = lf;
        if (in_item.last_byte)
        begin
            // flush leftover bits, then pad to a multiple of four
            if (ph == 2'd1)
            begin
                q_job.sym[1]   = {1'b0, lf[1:0], 4'b0000};
                q_job.sym[2]   = SYM_PAD;
                q_job.sym[3]   = SYM_PAD;
                q_job.last_idx = 2'd3;
            end
            else if (ph == 2'd2)
            begin
                q_job.sym[1]   = {1'b0, lf, 2'b00};
                q_job.sym[2]   = SYM_PAD;
                q_job.last_idx = 2'd2;
            end
            phase_next = 2'd0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            left_reg  <= 4'd0;
        end
        else if (q_wr)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase left its range");

    a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && in_item.last_byte) |=> (phase_reg == 2'd0 && left_reg == 4'd0))
        else $error("state not cleared after last byte");

endmodule

/* src/b64enc_fifo.sv */
// Job queue between front end and back end.
// Depends on b64enc_pkg.
module b64enc_fifo
    import b64enc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_job,
    input  logic rd,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("job queue overflow");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("job queue count lost a write");

endmodule

/* src/b64enc_back.sv */
// Back end: walks the head job one character per cycle into the output
// register; it stalls while the output is held. Depends on b64enc_pkg.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  job_t      q_job,
    output logic      q_rd,
    output out_item_t out_item,
    output logic      empty,
    input  logic      pop
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    out_item_t        out_reg;
    out_item_t        out_next;
    logic             emit;
    logic             at_last;

    assign empty    = !valid_reg;
    assign out_item = out_reg;
    assign at_last  = (idx_reg == q_job.last_idx);
    assign emit     = !q_empty && (!valid_reg || pop);
    assign q_rd     = emit && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        out_next   = out_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            out_next.out_char      = sym_to_ascii(q_job.sym[idx_reg]);
            out_next.end_of_output = q_job.eom && at_last;
            idx_next               = at_last ? '0 : idx_reg + 1'b1;
            valid_next             = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg <= q_job.last_idx))
        else $error("character index ran past its job");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (idx_reg == '0))
        else $error("character index not rewound");

endmodule

/* src/base64_stream_encoder_top.sv */
// Base64 stream encoder, standard alphabet with '=' padding.
// Each byte's job is queued, then its characters pass through the output register.
// Throughput: one character per cycle, set by the single output register, while a
// job waits and the output is free or popped; a byte gives 1 or 2 characters, the
// last byte of a message up to 4. Reset (async, rst_n low) clears group state and queues.
module base64_stream_encoder_top
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic q_wr;
    logic q_rd;
    logic q_empty;
    job_t wr_job;
    job_t rd_job;

    b64enc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_item (in_item),
        .q_full  (full),
        .q_wr    (q_wr),
        .q_job   (wr_job)
    );

    b64enc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_job (wr_job),
        .rd     (q_rd),
        .rd_job (rd_job),
        .full   (full),
        .empty  (q_empty)
    );

    b64enc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (rd_job),
        .q_rd     (q_rd),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
